/* design/sfcrc_pkg.sv */
// Shared types, codes and CRC-16 helpers for the short-frame CRC-16 receiver.
package sfcrc_pkg;

	// Request operation codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_REPLY  = 3'd1;
	localparam logic [2:0] ST_TRUNCATED = 3'd2;
	localparam logic [2:0] ST_CRC_BAD   = 3'd3;
	localparam logic [2:0] ST_END_BAD   = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_COPY_LIMIT    = 2'd0;
	localparam logic [1:0] REG_IDLE_LIMIT    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	// Configuration reset values
	localparam logic [7:0]  COPY_LIMIT_RST    = 8'd255;
	localparam logic [3:0]  IDLE_LIMIT_RST    = 4'd2;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

	// Frame delimiters
	localparam logic [7:0] FRAME_STX = 8'h02;
	localparam logic [7:0] FRAME_ETX = 8'h03;

	// One result item
	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [2:0] status;
		logic [7:0] frame_length;
	} result_t;

	// Nibble table of polynomial 0x1021
	function automatic logic [15:0] crc_nib_tab(input logic [3:0] idx);
		logic [15:0] val;
		case (idx)
			4'h0: val = 16'h0000;
			4'h1: val = 16'h1021;
			4'h2: val = 16'h2042;
			4'h3: val = 16'h3063;
			4'h4: val = 16'h4084;
			4'h5: val = 16'h50a5;
			4'h6: val = 16'h60c6;
			4'h7: val = 16'h70e7;
			4'h8: val = 16'h8108;
			4'h9: val = 16'h9129;
			4'ha: val = 16'ha14a;
			4'hb: val = 16'hb16b;
			4'hc: val = 16'hc18c;
			4'hd: val = 16'hd1ad;
			4'he: val = 16'he1ce;
			4'hf: val = 16'hf1ef;
			default: val = 16'h0000;
		endcase
		return val;
	endfunction

	// Advance the CRC by one nibble
	function automatic logic [15:0] crc_nib_step(input logic [15:0] crc, input logic [3:0] nib);
		return {crc[11:0], 4'h0} ^ crc_nib_tab(crc[15:12] ^ nib);
	endfunction

endpackage

/* design/sfcrc_crc_byte.sv */
// CRC-16 (poly 0x1021, MSB first) update by one byte, as two nibble steps.
module sfcrc_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import sfcrc_pkg::*;

	logic [15:0] crc_mid;

	// High nibble first, then low nibble
	assign crc_mid = crc_nib_step(crc_in, data[7:4]);
	assign crc_out = crc_nib_step(crc_mid, data[3:0]);

endmodule

/* design/short_frame_crc16_receiver.sv */
// Short-frame CRC-16 reply receiver: frame parser, CRC check and status report.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_stall    | operation, rx_byte
//  out     | out_valid / out_stall  | kind, payload_byte, byte_index, status,
//          |                        | frame_length
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while the output does not stall; a result passes the input register
// (loaded at the accepting edge) and then the output register.
// The per-byte CRC update (two nibble table steps) is the longest path.
// arst_n clears the frame state to "done, waiting for start" and loads the
// register defaults. Output stall holds the input register and raises in_stall.
// cfg_ready is always high; writes take effect on the next cycle.
module short_frame_crc16_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  byte_index,
	output logic [2:0]  status,
	output logic [7:0]  frame_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sfcrc_pkg::*;

	// Frame phase codes
	localparam logic [2:0] PH_DONE = 3'd0;
	localparam logic [2:0] PH_HUNT = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRCH = 3'd4;
	localparam logic [2:0] PH_CRCL = 3'd5;
	localparam logic [2:0] PH_END  = 3'd6;

	// Configuration registers
	logic [7:0]  copy_limit_q;
	logic [3:0]  idle_limit_q;
	logic [15:0] timeout_ticks_q;

	// Input register
	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;

	// Frame state
	logic [2:0]  phase_q,   phase_n;
	logic [7:0]  decl_len_q, decl_len_n;
	logic [7:0]  pay_cnt_q, pay_cnt_n;
	logic [15:0] crc_q,     crc_n;
	logic [15:0] crc_rx_q,  crc_rx_n;
	logic [3:0]  idle_run_q, idle_run_n;
	logic [15:0] ticks_q,   ticks_n;

	// Output register
	logic        out_vld_q;
	result_t     res_q;

	logic        res_vld;
	result_t     res;
	logic        out_free;
	logic        go;
	logic [15:0] crc_upd;
	logic [15:0] tick_limit;
	logic [7:0]  cnt_inc;

	assign out_free  = !out_vld_q || !out_stall;
	assign go        = vld_s1 && out_free;
	assign in_stall  = vld_s1 && !out_free;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_limit_q    <= COPY_LIMIT_RST;
			idle_limit_q    <= IDLE_LIMIT_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COPY_LIMIT:    copy_limit_q    <= cfg_data[7:0];
				REG_IDLE_LIMIT:    idle_limit_q    <= cfg_data[3:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the request, hold it while the output side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	sfcrc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	assign tick_limit = (timeout_ticks_q == 16'd0) ? 16'd1 : timeout_ticks_q;
	assign cnt_inc    = pay_cnt_q + 8'd1;

	// Parse one request against the frame state
	always_comb begin
		phase_n    = phase_q;
		decl_len_n = decl_len_q;
		pay_cnt_n  = pay_cnt_q;
		crc_n      = crc_q;
		crc_rx_n   = crc_rx_q;
		idle_run_n = idle_run_q;
		ticks_n    = ticks_q;
		res_vld    = 1'b0;
		res        = '{kind: KIND_STATUS, payload_byte: 8'd0, byte_index: 8'd0,
			status: ST_OK, frame_length: decl_len_q};

		if (op_s1 == OP_START) begin
			phase_n    = PH_HUNT;
			decl_len_n = 8'd0;
			pay_cnt_n  = 8'd0;
			crc_n      = 16'd0;
			crc_rx_n   = 16'd0;
			idle_run_n = 4'd0;
			ticks_n    = 16'd0;
		end else if (op_s1 == OP_TICK && phase_q != PH_DONE) begin
			if (ticks_q != 16'hFFFF) begin
				ticks_n = ticks_q + 16'd1;
			end
			if (phase_q != PH_HUNT && idle_run_q != 4'hF) begin
				idle_run_n = idle_run_q + 4'd1;
			end
			if (phase_q != PH_HUNT && idle_run_n >= idle_limit_q) begin
				res_vld    = 1'b1;
				res.status = ST_TRUNCATED;
				phase_n    = PH_DONE;
			end else if (ticks_n >= tick_limit) begin
				res_vld    = 1'b1;
				res.status = (phase_q == PH_HUNT) ? ST_NO_REPLY : ST_TRUNCATED;
				phase_n    = PH_DONE;
			end
		end else if (op_s1 == OP_BYTE && phase_q != PH_DONE) begin
			idle_run_n = 4'd0;
			case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == FRAME_STX) begin
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					decl_len_n = byte_s1;
					pay_cnt_n  = 8'd0;
					crc_n      = 16'd0;
					phase_n    = (byte_s1 == 8'd0) ? PH_CRCH : PH_DATA;
				end
				PH_DATA: begin
					crc_n     = crc_upd;
					pay_cnt_n = cnt_inc;
					if (cnt_inc >= decl_len_q) begin
						phase_n = PH_CRCH;
					end
					if (pay_cnt_q < copy_limit_q) begin
						res_vld          = 1'b1;
						res.kind         = KIND_DATA;
						res.payload_byte = byte_s1;
						res.byte_index   = pay_cnt_q;
					end
				end
				PH_CRCH: begin
					crc_rx_n = {8'd0, byte_s1};
					phase_n  = PH_CRCL;
				end
				PH_CRCL: begin
					crc_rx_n = {crc_rx_q[7:0], byte_s1};
					phase_n  = PH_END;
				end
				PH_END: begin
					res_vld = 1'b1;
					phase_n = PH_DONE;
					if (crc_rx_q != crc_q) begin
						res.status = ST_CRC_BAD;
					end else if (byte_s1 != FRAME_ETX) begin
						res.status = ST_END_BAD;
					end else begin
						res.status = ST_OK;
					end
				end
				default: phase_n = PH_DONE;
			endcase
		end
	end

	// Advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DONE;
			decl_len_q <= 8'd0;
			pay_cnt_q  <= 8'd0;
			crc_q      <= 16'd0;
			crc_rx_q   <= 16'd0;
			idle_run_q <= 4'd0;
			ticks_q    <= 16'd0;
		end else if (go) begin
			phase_q    <= phase_n;
			decl_len_q <= decl_len_n;
			pay_cnt_q  <= pay_cnt_n;
			crc_q      <= crc_n;
			crc_rx_q   <= crc_rx_n;
			idle_run_q <= idle_run_n;
			ticks_q    <= ticks_n;
		end
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= go && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_vld) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_vld_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign byte_index   = res_q.byte_index;
	assign status       = res_q.status;
	assign frame_length = res_q.frame_length;

`ifndef NO_ASSERTIONS
	// A status result always closes the frame
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res_vld && res.kind == KIND_STATUS) |=> (phase_q == PH_DONE))
		else $error("status result did not close the frame");

	// Payload count stays below the declared length while collecting data
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (pay_cnt_q < decl_len_q))
		else $error("payload count reached declared length in data phase");

	// Input stall only while a request waits in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_vld_q && out_stall))
		else $error("input stalled without a blocked request");

	// A start request rearms the hunt with a fresh tick budget
	a_start_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(go && op_s1 == OP_START) |=> (phase_q == PH_HUNT && ticks_q == 16'd0))
		else $error("start request did not rearm the hunt");

	// No result leaves a done frame
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(go && phase_q == PH_DONE) |-> !res_vld)
		else $error("result produced while done");
`endif

endmodule

/* bench/sfcrc_checker.sv */
// Checker for the short-frame CRC-16 receiver: predicts results and compares them.
module sfcrc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  byte_index,
	input  logic [2:0]  status,
	input  logic [7:0]  frame_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending,
	output int          bytes_seen,
	output int          status_seen,
	output logic [4:0]  status_mask
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfcrc_pkg::*;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int          REPORT_MAX = 10;

	typedef enum logic [2:0] {
		PH_DONE, PH_HUNT, PH_LEN, PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_END
	} rx_phase_t;

	// Shadow registers and frame state
	logic [7:0]  copy_limit;
	logic [3:0]  idle_limit;
	logic [15:0] timeout_ticks;
	rx_phase_t   phase;
	logic [7:0]  frame_len;
	logic [7:0]  rcvd_count;
	logic [15:0] crc_acc;
	logic [15:0] crc_rx;
	logic [3:0]  idle_run;
	logic [15:0] ticks_used;
	result_t     expected_q[$];

	// Bitwise CRC-16, MSB first, polynomial 0x1021
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// Close the frame with a status result
	task automatic close_frame(input logic [2:0] st);
		result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.frame_length = frame_len;
		expected_q.push_back(r);
		phase = PH_DONE;
	endtask

	// Advance the receiver state by one request
	task automatic step_request(input logic [1:0] op, input logic [7:0] b);
		logic [15:0] limit;
		result_t     r;
		if (op == OP_START) begin
			phase = PH_HUNT;
			frame_len = '0;
			rcvd_count = '0;
			crc_acc = '0;
			crc_rx = '0;
			idle_run = '0;
			ticks_used = '0;
		end else if (op == OP_TICK && phase != PH_DONE) begin
			limit = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
			if (ticks_used != 16'hFFFF)
				ticks_used++;
			if (phase != PH_HUNT && idle_run != 4'hF)
				idle_run++;
			if (phase != PH_HUNT && idle_run >= idle_limit)
				close_frame(ST_TRUNCATED);
			else if (ticks_used >= limit)
				close_frame(phase == PH_HUNT ? ST_NO_REPLY : ST_TRUNCATED);
		end else if (op == OP_BYTE && phase != PH_DONE) begin
			idle_run = '0;
			case (phase)
				PH_HUNT: begin
					if (b == FRAME_STX)
						phase = PH_LEN;
				end
				PH_LEN: begin
					frame_len = b;
					rcvd_count = '0;
					crc_acc = '0;
					phase = (b == '0) ? PH_CRC_HI : PH_DATA;
				end
				PH_DATA: begin
					if (rcvd_count < copy_limit) begin
						r = '0;
						r.kind = KIND_DATA;
						r.payload_byte = b;
						r.byte_index = rcvd_count;
						r.frame_length = frame_len;
						expected_q.push_back(r);
					end
					crc_acc = crc_update(crc_acc, b);
					rcvd_count++;
					if (rcvd_count >= frame_len)
						phase = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					crc_rx = {8'h00, b};
					phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					crc_rx = {crc_rx[7:0], b};
					phase = PH_END;
				end
				PH_END: begin
					if (crc_rx != crc_acc)
						close_frame(ST_CRC_BAD);
					else if (b != FRAME_ETX)
						close_frame(ST_END_BAD);
					else
						close_frame(ST_OK);
				end
				default: begin
					phase = PH_DONE;
				end
			endcase
		end
	endtask

	// Count a mismatch, report only the first few
	task automatic flag_mismatch(input string why, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t %s: want k=%0d b=%02h i=%0d s=%0d l=%0d, got k=%0d b=%02h i=%0d s=%0d l=%0d",
				$time, why, want.kind, want.payload_byte, want.byte_index, want.status,
				want.frame_length, got.kind, got.payload_byte, got.byte_index, got.status,
				got.frame_length);
	endtask

	// Compare one result against the oldest expectation
	task automatic check_result();
		result_t got;
		result_t want;
		got = {kind, payload_byte, byte_index, status, frame_length};
		if (expected_q.size() == 0) begin
			flag_mismatch("result with nothing expected", '0, got);
		end else begin
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
					got.byte_index !== want.byte_index || got.status !== want.status ||
					got.frame_length !== want.frame_length) begin
				flag_mismatch("result mismatch", want, got);
			end else if (want.kind == KIND_STATUS) begin
				status_seen++;
				status_mask[want.status] = 1'b1;
			end else begin
				bytes_seen++;
			end
		end
	endtask

	// Watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_limit = COPY_LIMIT_RST;
			idle_limit = IDLE_LIMIT_RST;
			timeout_ticks = TIMEOUT_TICKS_RST;
			phase = PH_DONE;
			frame_len = '0;
			rcvd_count = '0;
			crc_acc = '0;
			crc_rx = '0;
			idle_run = '0;
			ticks_used = '0;
			expected_q.delete();
			mismatches = 0;
			bytes_seen = 0;
			status_seen = 0;
			status_mask = '0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				step_request(operation, rx_byte);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COPY_LIMIT:    copy_limit = cfg_data[7:0];
					REG_IDLE_LIMIT:    idle_limit = cfg_data[3:0];
					REG_TIMEOUT_TICKS: timeout_ticks = cfg_data;
					default: ;
				endcase
			end
			pending <= expected_q.size();
		end
	end

endmodule

/* bench/testbench.sv */
// Testbench top for the short-frame CRC-16 receiver: stimulus, pacing and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sfcrc_pkg::*;

	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [1:0] REG_SPARE     = 2'd3;
	localparam int         RANDOM_ITEMS  = 1300;
	localparam int         NUM_SETTINGS  = 6;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         HOLD_CYCLES   = 90;
	localparam int         CYCLE_LIMIT   = 400000;

	typedef enum int {
		FL_GOOD, FL_CRC, FL_END, FL_TRUNC, FL_RESTART, FL_SILENT, FL_NOISE
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic [2:0]  status;
	logic [7:0]  frame_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int          mismatches;
	int          pending;
	int          bytes_seen;
	int          status_seen;
	logic [4:0]  status_mask;

	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	int          items_sent;
	int          cycle_count;
	logic [3:0]  cur_idle;
	logic [15:0] cur_timeout;

	// Register settings per random phase, extremes included
	logic [15:0] set_copy[NUM_SETTINGS] = '{16'd255, 16'd0, 16'd3, 16'hAB05, 16'd128, 16'd255};
	logic [15:0] set_idle[NUM_SETTINGS] = '{16'd2, 16'd1, 16'd15, 16'd0, 16'd7, 16'd4};
	logic [15:0] set_tmo[NUM_SETTINGS]  = '{16'd100, 16'd65535, 16'd1, 16'd0, 16'd300, 16'd25};

	short_frame_crc16_receiver u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.payload_byte(payload_byte), .byte_index(byte_index), .status(status),
		.frame_length(frame_length),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sfcrc_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.payload_byte(payload_byte), .byte_index(byte_index), .status(status),
		.frame_length(frame_length),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending), .bytes_seen(bytes_seen),
		.status_seen(status_seen), .status_mask(status_mask)
	);

	always #6 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Drive receiver stall; on request hold off for a long stretch
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Frame CRC for stimulus, built from the package nibble step
	function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] d);
		return crc_nib_step(crc_nib_step(crc, d[7:4]), d[3:0]);
	endfunction

	// Offer one request and hold it until accepted
	task automatic put(input logic [1:0] op, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
	endtask

	// Request that the block ignores once done: byte, tick or the unused code
	task automatic put_stray(input logic [7:0] b);
		logic [1:0] op;
		case ($urandom_range(2))
			0:       op = OP_BYTE;
			1:       op = OP_TICK;
			default: op = OP_UNUSED;
		endcase
		put(op, b);
	endtask

	// Drop valid and wait until every expected result is out
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] copy, input logic [15:0] idle,
			input logic [15:0] tmo);
		write_reg(REG_COPY_LIMIT, copy);
		write_reg(REG_IDLE_LIMIT, idle);
		write_reg(REG_TIMEOUT_TICKS, tmo);
		cur_idle = idle[3:0];
		cur_timeout = tmo;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom_range(255, 100);
		else if (r < 18)
			return 0;
		return $urandom_range(12, 1);
	endfunction

	function automatic flaw_t pick_flaw();
		int r;
		r = $urandom_range(99);
		if (r < 55) return FL_GOOD;
		if (r < 65) return FL_CRC;
		if (r < 75) return FL_END;
		if (r < 85) return FL_TRUNC;
		if (r < 90) return FL_RESTART;
		if (r < 95) return (cur_timeout <= 300) ? FL_SILENT : FL_GOOD;
		return FL_NOISE;
	endfunction

	// One reply: start, hunt noise, then a frame shaped by the flaw, or ticks or stray requests
	task automatic frame(input int len, input flaw_t flaw);
		logic [15:0] crc;
		logic [7:0]  tail[$];
		logic [7:0]  d;
		int          n_send;
		int          n_ticks;
		bit          gap_ok;
		crc = '0;
		gap_ok = (cur_idle >= 2) && (cur_timeout >= 40);
		put(OP_START, 8'($urandom));
		repeat ($urandom_range(2)) begin
			d = 8'($urandom);
			put(OP_BYTE, (d == FRAME_STX) ? 8'hFF : d);
		end
		if (gap_ok && $urandom_range(3) == 0)
			put(OP_TICK, 8'($urandom));
		if (flaw == FL_SILENT) begin
			n_ticks = (cur_timeout == '0) ? 1 : int'(cur_timeout);
			repeat (n_ticks) put(OP_TICK, 8'($urandom));
		end else if (flaw == FL_NOISE) begin
			repeat ($urandom_range(12, 4))
				put_stray(($urandom_range(3) == 0) ? FRAME_STX : 8'($urandom));
		end else begin
			// Build payload, CRC and end byte
			for (int k = 0; k < len; k++) begin
				d = 8'($urandom);
				tail.push_back(d);
				crc = crc_after(crc, d);
			end
			tail.push_back(crc[15:8]);
			tail.push_back(crc[7:0]);
			tail.push_back(FRAME_ETX);
			if (flaw == FL_CRC)
				tail[len + $urandom_range(1)] ^= (8'h01 << $urandom_range(7));
			if (flaw == FL_END)
				tail[len + 2] = FRAME_ETX ^ 8'($urandom_range(255, 1));
			n_send = (flaw == FL_TRUNC || flaw == FL_RESTART) ?
				$urandom_range(len + 1) : len + 3;
			put(OP_BYTE, FRAME_STX);
			if (flaw == FL_TRUNC && $urandom_range(5) == 0)
				n_send = -1;
			else
				put(OP_BYTE, 8'(len));
			for (int k = 0; k < n_send; k++) begin
				if (gap_ok && $urandom_range(9) == 0)
					put(OP_TICK, 8'($urandom));
				put(OP_BYTE, tail[k]);
			end
			// End the partial frame by idle ticks
			if (flaw == FL_TRUNC) begin
				n_ticks = (cur_idle == '0) ? 1 : int'(cur_idle);
				repeat (n_ticks) put(OP_TICK, 8'($urandom));
			end
		end
		if (flaw != FL_RESTART && $urandom_range(3) == 0)
			put_stray(8'($urandom));
	endtask

	initial begin
		logic [15:0] crc;
		int          base;
		int          target;
		bit          held;
		in_valid = 1'b0;
		operation = OP_BYTE;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COPY_LIMIT;
		cfg_data = '0;
		arst_n = 1'b0;
		hold_req = 1'b0;
		held = 1'b0;
		items_sent = 0;
		cycle_count = 0;
		cur_idle = IDLE_LIMIT_RST;
		cur_timeout = TIMEOUT_TICKS_RST;
		send_idle_pct = 14;
		recv_stall_pct = 57;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ignored requests while done, then frames ending ok, bad CRC, bad end, truncated, cut short
		put(OP_TICK, 8'h00);
		put(OP_BYTE, 8'hFF);
		put(OP_UNUSED, 8'hAA);
		crc = crc_after(crc_after(16'h0000, 8'h00), 8'hFF);
		put(OP_START, 8'h00);
		put(OP_BYTE, FRAME_STX);
		put(OP_BYTE, 8'd2);
		put(OP_BYTE, 8'h00);
		put(OP_BYTE, 8'hFF);
		put(OP_BYTE, crc[15:8]);
		put(OP_BYTE, crc[7:0]);
		put(OP_BYTE, FRAME_ETX);
		frame(0, FL_CRC);
		frame(0, FL_END);
		frame(1, FL_TRUNC);
		frame(2, FL_RESTART);
		quiesce();

		// Random phases, one register setting each
		base = items_sent;
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			set_regs(set_copy[p], set_idle[p], set_tmo[p]);
			if (p == 3)
				write_reg(REG_SPARE, 16'hFFFF);
			target = base + RANDOM_ITEMS * (p + 1) / NUM_SETTINGS;
			while (items_sent < target) begin
				if (items_sent - base < RANDOM_ITEMS / 3) begin
					send_idle_pct = 14;
					recv_stall_pct = 57;
				end else if (items_sent - base < 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 57;
					recv_stall_pct = 14;
				end else begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				// Long receiver hold-off while a long frame streams in
				if (p == 0 && !held && items_sent - base > 60) begin
					held = 1'b1;
					hold_req = 1'b1;
					frame(60, FL_GOOD);
				end else begin
					frame(pick_len(), pick_flaw());
				end
			end
			quiesce();
		end

		$display("Checked %0d requests: %0d payload bytes and %0d statuses across %0d settings",
			items_sent, bytes_seen, status_seen, NUM_SETTINGS);
		$display("Status codes seen (bad end, crc, truncated, no reply, ok): %b", status_mask);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
